// File: hw/rtl/upd_pkg.sv
// Shared types, constants and helper functions for the URL percent decoder.
// No dependencies; every other file of the block but upd_checker imports this package.
package upd_pkg;

   localparam logic [7:0] PCT_CHAR = 8'h25;

   // What the front end has held back while an escape is still open.
   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_PCT,
      HOLD_DIGIT
   } hold_type;

   // One classified input: up to three output bytes, oldest first.
   typedef struct packed {
      logic [1:0] count;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic       last;
   } cmd_type;

   function automatic logic is_hex(input logic [7:0] b);
      is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46);
   endfunction

   // Nibble value of an uppercase hex digit; only meaningful when is_hex holds.
   function automatic logic [3:0] hex_nibble(input logic [7:0] b);
      logic [7:0] diff;
      if (b <= 8'h39) begin
         diff = b - 8'h30;
      end else begin
         diff = b - 8'h37;
      end
      hex_nibble = diff[3:0];
   endfunction

endpackage

// File: hw/rtl/url_percent_decoder.sv
// URL percent decoder, top level: upd_front, upd_cmd_queue and upd_back.
// Depends on upd_pkg and the three submodules.
//
// Usage: the input side is a queue write port. A beat (req_in_byte,
// req_in_last) is taken at a rising edge with req_push high and req_full
// low. Each '%' followed by two uppercase hex digits becomes one decoded
// byte; anything else passes through, and the last output byte of a string
// carries rsp_out_last. The result side is a queue read port: while
// rsp_empty is low the oldest result is on rsp_out_byte / rsp_out_last,
// and a rising edge with rsp_pop high takes it.
// Results pass the command queue, then the result register. Throughput,
// unless a side stalls: one input beat and one result per cycle; the back
// end serializes a command at one byte per cycle, so a failed escape that
// releases two or three bytes costs extra output cycles, absorbed by the
// QUEUE_DEPTH-entry command queue before req_full rises.
// When the receiver stalls, the result register holds its byte and the
// queue fills; req_full then holds off the sender. Reset empties the queue
// and the result register and drops any held partial escape.
module url_percent_decoder
   import upd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   logic    accept;
   logic    cmd_valid;
   cmd_type cmd;
   cmd_type head_cmd;
   logic    queue_empty;
   logic    head_done;
   logic    out_valid;

   assign accept = req_push && !req_full;

   upd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .in_last   (req_in_last),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   upd_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (cmd_valid),
      .wr_cmd (cmd),
      .rd_en  (head_done),
      .rd_cmd (head_cmd),
      .empty  (queue_empty),
      .full   (req_full)
   );

   upd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!queue_empty),
      .head_cmd   (head_cmd),
      .head_done  (head_done),
      .pop        (rsp_pop),
      .out_valid  (out_valid),
      .out_byte   (rsp_out_byte),
      .out_last   (rsp_out_last)
   );

   assign rsp_empty = !out_valid;

endmodule

// File: hw/rtl/upd_front.sv
// Front end of the percent decoder: accepts input beats, tracks the escape
// hold state and turns each beat into a command of zero to three bytes. Uses upd_pkg.
module upd_front
   import upd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output logic       cmd_valid,
   output cmd_type    cmd
);

   hold_type   hold_ff, hold_in;
   logic [7:0] digit_ff, digit_in;
   logic       starts_escape;
   logic       byte_is_hex;

   assign starts_escape = (in_byte == PCT_CHAR) && !in_last;
   assign byte_is_hex   = is_hex(in_byte);

   always_comb begin
      hold_in  = hold_ff;
      digit_in = digit_ff;
      if (accept) begin
         unique case (hold_ff)
            HOLD_PCT: begin
               if (byte_is_hex && !in_last) begin
                  hold_in  = HOLD_DIGIT;
                  digit_in = in_byte;
               end else if (starts_escape) begin
                  hold_in = HOLD_PCT;
               end else begin
                  hold_in = HOLD_NONE;
               end
            end
            HOLD_DIGIT: begin
               if (!byte_is_hex && starts_escape) begin
                  hold_in = HOLD_PCT;
               end else begin
                  hold_in = HOLD_NONE;
               end
            end
            default: begin
               hold_in = starts_escape ? HOLD_PCT : HOLD_NONE;
            end
         endcase
      end
   end

   always_comb begin
      cmd.count = 2'd0;
      cmd.byte0 = in_byte;
      cmd.byte1 = in_byte;
      cmd.byte2 = in_byte;
      cmd.last  = in_last;
      unique case (hold_ff)
         HOLD_PCT: begin
            if (!(byte_is_hex && !in_last)) begin
               // Failed escape: release the percent sign and rescan the new byte.
               cmd.byte0 = PCT_CHAR;
               cmd.count = starts_escape ? 2'd1 : 2'd2;
            end
         end
         HOLD_DIGIT: begin
            if (byte_is_hex) begin
               cmd.byte0 = {hex_nibble(digit_ff), hex_nibble(in_byte)};
               cmd.count = 2'd1;
            end else begin
               cmd.byte0 = PCT_CHAR;
               cmd.byte1 = digit_ff;
               cmd.count = starts_escape ? 2'd2 : 2'd3;
            end
         end
         default: begin
            cmd.count = starts_escape ? 2'd0 : 2'd1;
         end
      endcase
   end

   assign cmd_valid = accept && (cmd.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= HOLD_NONE;
      end else begin
         hold_ff <= hold_in;
      end
      digit_ff <= digit_in;
   end

endmodule

// File: hw/rtl/upd_cmd_queue.sv
// Short command queue that decouples the front end from the output serializer.
// Stores cmd_type entries from upd_pkg in a register ring.
module upd_cmd_queue
   import upd_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_cmd,
   input  logic    rd_en,
   output cmd_type rd_cmd,
   output logic    empty,
   output logic    full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
      bump = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   assign empty  = (count_ff == '0);
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign rd_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = rd_en ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

// File: hw/rtl/upd_back.sv
// Back end of the percent decoder: walks the bytes of the head command and
// feeds them one per beat into the result register. Uses upd_pkg.
module upd_back
   import upd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  cmd_type    head_cmd,
   output logic       head_done,
   input  logic       pop,
   output logic       out_valid,
   output logic [7:0] out_byte,
   output logic       out_last
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       load;
   logic       final_byte;

   // The result register refills from a non-empty queue whenever it is empty or being drained.
   assign load       = head_valid && (!valid_ff || pop);
   assign final_byte = (idx_ff == head_cmd.count - 2'd1);
   assign head_done  = load && final_byte;

   always_comb begin
      unique case (idx_ff)
         2'd0:    byte_in = head_cmd.byte0;
         2'd1:    byte_in = head_cmd.byte1;
         default: byte_in = head_cmd.byte2;
      endcase
      last_in  = head_cmd.last && final_byte;
      valid_in = load || (valid_ff && !pop);
      idx_in   = idx_ff;
      if (load) begin
         idx_in = final_byte ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

// File: hw/rtl/upd_checker.sv
// Port-level checks for url_percent_decoder, attached by the bind below.
// Sees only the top-level ports; no package dependency.
module upd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_push,
   input logic       req_full,
   input logic [7:0] req_in_byte,
   input logic       req_in_last,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last
);

   // Reset must leave the result side empty and the command queue not full.
   assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("reset did not clear the result and input sides");

   // A result that is not taken stays put.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_out_byte) && $stable(rsp_out_last)))
      else $error("stalled result changed");

   // A one-byte string right after reset reaches the result side through the queue.
   assert property (@(posedge clock) disable iff (reset)
      ($past(reset) && req_push && !req_full && req_in_last) |=> ##1 !rsp_empty)
      else $error("first result missing after a single-byte string");

   // That same byte comes out unchanged and marked last.
   assert property (@(posedge clock) disable iff (reset)
      ($past(reset) && req_push && !req_full && req_in_last) |=> ##1
         (rsp_out_last && rsp_out_byte == $past(req_in_byte, 2)))
      else $error("single-byte string not passed through as last byte");

endmodule

bind url_percent_decoder upd_checker u_checker (.*);
